FILE: sv/sidec_pkg.sv
`timescale 1ns / 1ps
// Package for the signed integer to decimal ASCII unit.
// Holds character codes, the divide-by-ten reciprocal, the sequencer states
// and the control and status structs between the sequencer and the divider.
package sidec_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGITS_MAX = 10;
    localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);
    localparam int COUNT_W    = 4;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic rem;
    } div_ctrl_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       quot_zero;
    } div_stat_t;

endpackage

FILE: sv/sidec_div10.sv
`timescale 1ns / 1ps
// Shared divide-by-ten step: reciprocal multiply into a product register, remainder and
// quotient update in the next cycle. Depends on sidec_pkg.
module sidec_div10
    import sidec_pkg::*;
(
    input  logic               clk,
    input  div_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] dividend,
    output div_stat_t          stat
);

    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    logic [2*VALUE_W-1:0] prod_reg;
    logic [2*VALUE_W-1:0] prod_next;
    logic [QUOT_W-1:0]    quot;
    logic [VALUE_W-1:0]   quot_ten;
    logic [VALUE_W-1:0]   rem;

    assign quot     = prod_reg[2*VALUE_W-1:RECIP_SHIFT];
    // q * 10 as q*8 + q*2
    assign quot_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = mag_reg - quot_ten;

    assign stat.digit     = rem[3:0];
    assign stat.quot_zero = (quot == '0);

    always_comb
    begin
        prod_next = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
        mag_next  = mag_reg;
        if (ctrl.load)
        begin
            mag_next = dividend;
        end
        else if (ctrl.rem)
        begin
            mag_next = {{(VALUE_W-QUOT_W){1'b0}}, quot};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: sv/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: value[31:0], plus_flag[32], space_flag[33]
// m_*      out  m_tvalid/m_tready  m_tdata: text_char[7:0], char_count[11:8]; m_tlast
//
// Each integer is taken while idle; each digit then takes a multiply step and a
// remainder step in the shared divide-by-ten unit, and the characters then pass
// one by one through the output register, the sign character first.
// s_tready is high only while idle; the last character may still wait in the
// output register while the next word is taken. A stalled m_tready holds
// the output register and the emit pointer. rst_n clears control at once.
// Depends on sidec_pkg and sidec_div10.
module signed_int_to_decimal_ascii_unit
    import sidec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], plus_flag[32], space_flag[33], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // text_char[7:0], char_count[11:8], zero fill
    output logic        m_tlast
);

    seq_state_t state_reg, state_next;

    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    logic [VALUE_W-1:0]   value_in;
    logic [VALUE_W-1:0]   magnitude;
    logic                 accept;

    logic [3:0]           digit_mem [DIGITS_MAX];
    logic [DIG_IDX_W-1:0] ndig_reg, ndig_next;
    logic [DIG_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic                 has_sign_reg, has_sign_next;
    logic                 sign_pend_reg, sign_pend_next;
    logic [CHAR_W-1:0]    sign_char_reg, sign_char_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_load;
    logic [CHAR_W-1:0]    cur_char;
    logic                 cur_last;

    assign value_in  = s_tdata[VALUE_W-1:0];
    assign magnitude = value_in[VALUE_W-1] ? (VALUE_W'(0) - value_in) : value_in;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign out_load  = !out_valid_reg || m_tready;
    assign cur_char  = sign_pend_reg ? sign_char_reg
                                     : (CHAR_ZERO + {4'b0000, digit_mem[rd_idx_reg]});
    assign cur_last  = !sign_pend_reg && (rd_idx_reg == '0);

    sidec_div10 u_div10 (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (magnitude),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        div_ctrl       = '0;
        ndig_next      = ndig_reg;
        rd_idx_next    = rd_idx_reg;
        has_sign_next  = has_sign_reg;
        sign_pend_next = sign_pend_reg;
        sign_char_next = sign_char_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    div_ctrl.load = 1'b1;
                    ndig_next     = '0;
                    priority if (value_in[VALUE_W-1])
                    begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CHAR_MINUS;
                    end
                    else if (s_tdata[32])
                    begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CHAR_PLUS;
                    end
                    else if (s_tdata[33])
                    begin
                        has_sign_next  = 1'b1;
                        sign_char_next = CHAR_SPACE;
                    end
                    else
                    begin
                        has_sign_next  = 1'b0;
                        sign_char_next = CHAR_SPACE;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_ctrl.mul = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                div_ctrl.rem = 1'b1;
                if (div_stat.quot_zero)
                begin
                    // ndig_reg is now the index of the most significant digit
                    rd_idx_next    = ndig_reg;
                    sign_pend_next = has_sign_reg;
                    count_next     = COUNT_W'(ndig_reg) + COUNT_W'(1)
                                     + COUNT_W'(has_sign_reg);
                    state_next     = ST_EMIT;
                end
                else
                begin
                    ndig_next  = ndig_reg + DIG_IDX_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = cur_char;
                    out_count_next = count_reg;
                    out_last_next  = cur_last;
                    priority if (sign_pend_reg)
                    begin
                        sign_pend_next = 1'b0;
                    end
                    else if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - DIG_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ndig_reg      <= ndig_next;
        rd_idx_reg    <= rd_idx_next;
        has_sign_reg  <= has_sign_next;
        sign_pend_reg <= sign_pend_next;
        sign_char_reg <= sign_char_next;
        count_reg     <= count_next;
        out_char_reg  <= out_char_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        // digits land least significant first
        if (div_ctrl.rem)
        begin
            digit_mem[ndig_reg] <= div_stat.digit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/sidec_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the signed integer to decimal ASCII unit, bound to
// the top level. Depends on sidec_pkg for character codes.
module sidec_checker
    import sidec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // hold the output word while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= 4'd11))
        else $error("character count out of range");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("output fill bits not zero");

    // the final character is always a digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[7:0] >= CHAR_ZERO)
                                && (m_tdata[7:0] <= CHAR_ZERO + 8'd9))
        else $error("last character is not a digit");

    // an accepted word starts a conversion, so s_tready drops after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

endmodule

bind signed_int_to_decimal_ascii_unit sidec_checker u_sidec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii_unit: drives integer words with sign flags
// and checks every emitted character against a local decimal formatter.
// Depends on sidec_pkg and the unit's RTL.
module tb;
    import sidec_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } text_char_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    logic [39:0] pending_words[$];
    text_char_t  expected_text[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic stall_go      = 1'b0;
    int   stall_left    = 0;
    int   errors        = 0;
    int   words_sent    = 0;
    int   chars_checked = 0;
    int   quiet_cycles  = 0;

    signed_int_to_decimal_ascii_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [39:0] make_word(input logic [31:0] v, input logic plus,
                                              input logic space);
        return {6'b0, space, plus, v};
    endfunction

    // Format one word as printf-style decimal text and queue its characters.
    function automatic void push_decimal_text(input logic [39:0] word);
        logic [31:0]       mag;
        logic [CHAR_W-1:0] digits[DIGITS_MAX];
        logic [CHAR_W-1:0] text[DIGITS_MAX+1];
        int                ndig;
        int                len;
        text_char_t        c;
        mag  = word[31] ? (32'd0 - word[31:0]) : word[31:0];
        ndig = 0;
        do begin
            digits[ndig] = CHAR_ZERO + CHAR_W'(mag % 32'd10);
            ndig++;
            mag = mag / 32'd10;
        end while (mag != 0 && ndig < DIGITS_MAX);
        len = 0;
        if (word[31])
        begin
            text[len] = CHAR_MINUS;
            len++;
        end
        else if (word[32])
        begin
            text[len] = CHAR_PLUS;
            len++;
        end
        else if (word[33])
        begin
            text[len] = CHAR_SPACE;
            len++;
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            text[len] = digits[k];
            len++;
        end
        for (int k = 0; k < len; k++)
        begin
            c.ch    = text[k];
            c.last  = (k == len - 1);
            c.count = COUNT_W'(len);
            expected_text.push_back(c);
        end
    endfunction

    // Mix full-range values, short numbers and values at digit-count boundaries.
    function automatic logic [31:0] rand_value();
        int          kind;
        int          e;
        logic [31:0] v;
        kind = $urandom_range(9);
        if (kind < 4)
        begin
            v = $urandom();
        end
        else if (kind < 7)
        begin
            v = $urandom_range(999);
            if ($urandom_range(1) != 0)
                v = 32'd0 - v;
        end
        else
        begin
            e = $urandom_range(9);
            v = 32'd1;
            repeat (e) v = v * 32'd10;
            v = v - 32'($urandom_range(1));
            if ($urandom_range(1) != 0)
                v = 32'd0 - v;
        end
        return v;
    endfunction

    function automatic void push_random_words(input int n);
        repeat (n)
            pending_words.push_back(make_word(rand_value(), 1'($urandom_range(1)),
                                              1'($urandom_range(1))));
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_text.size() != 0)
            @(negedge clk);
    endtask

    // Driver: hold the word until taken, then offer the next one or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                push_decimal_text(s_tdata);
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each character word, then pick the next ready level.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        text_char_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected char %h last %b count %0d", $time,
                                 m_tdata[7:0], m_tlast, m_tdata[11:8]);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
                        m_tdata[11:8] !== want.count)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: char exp %h/%b/%0d got %h/%b/%0d", $time,
                                     want.ch, want.last, want.count,
                                     m_tdata[7:0], m_tlast, m_tdata[11:8]);
                    end
                end
            end
            if (stall_go)
            begin
                stall_left <= LONG_STALL;
                m_tready   <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        send_idle_pct = 32;
        recv_idle_pct = 82;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Zero with every flag mix, small values, sign flags on negatives
        pending_words.push_back(make_word(32'd0, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'd0, 1'b1, 1'b0));
        pending_words.push_back(make_word(32'd0, 1'b0, 1'b1));
        pending_words.push_back(make_word(32'd0, 1'b1, 1'b1));
        pending_words.push_back(make_word(32'd1, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'hFFFF_FFFF, 1'b1, 1'b1));
        pending_words.push_back(make_word(32'hFFFF_FFFF, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'd9, 1'b0, 1'b1));
        pending_words.push_back(make_word(32'd10, 1'b1, 1'b0));
        pending_words.push_back(make_word(32'd0 - 32'd10, 1'b0, 1'b1));
        pending_words.push_back(make_word(32'd99, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'd100, 1'b0, 1'b1));
        pending_words.push_back(make_word(32'd999_999_999, 1'b1, 1'b0));
        pending_words.push_back(make_word(32'd1_000_000_000, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'd1_234_567_890, 1'b0, 1'b1));
        pending_words.push_back(make_word(32'd0 - 32'd123_456_789, 1'b1, 1'b0));
        // Both 32-bit extremes; the most negative one has no positive twin
        pending_words.push_back(make_word(32'h7FFF_FFFF, 1'b1, 1'b1));
        pending_words.push_back(make_word(32'h7FFF_FFFF, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'h8000_0000, 1'b0, 1'b0));
        pending_words.push_back(make_word(32'h8000_0000, 1'b1, 1'b1));
        pending_words.push_back(make_word(32'h8000_0001, 1'b0, 1'b1));

        // Block the receiver while words keep coming so the unit backs up
        @(negedge clk) stall_go <= 1'b1;
        @(negedge clk) stall_go <= 1'b0;
        push_random_words(80);
        wait_drained();

        @(negedge clk);
        send_idle_pct = 82;
        recv_idle_pct = 32;
        push_random_words(80);
        wait_drained();

        @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_words(100);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Formatted %0d integers into %0d checked characters, covering both", words_sent,
                 chars_checked);
        $display("32-bit extremes, all sign-flag mixes, three idle mixes and a long stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
